/* rtl/vnfis_pkg.sv */
`default_nettype none
package vnfis_pkg;

    localparam int unsigned FW = 32;
    localparam int unsigned NSTAGE = 12;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW = 2;

    localparam logic [31:0] MAGIC_SEED = 32'h5f3759df;
    localparam logic [31:0] FP_HALF = 32'h3f000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
    localparam logic [31:0] FP_DEFAULT_NAN = 32'hffc00000;
    localparam logic [31:0] FP_QUIET_BIT = 32'h00400000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] m;
        logic [31:0] r;
        logic [31:0] t;
    } item_t;

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic sr;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [4:0] la;
        logic [4:0] lb;
        logic signed [11:0] xa;
        logic signed [11:0] xb;
        logic signed [11:0] xe;
        logic signed [11:0] sh;
        logic [47:0] p;
        logic stk;
        logic [23:0] mant;
        logic rnd;
        logic [7:0] eadj;
        logic [30:0] mag;
        logic [31:0] res;
        sr = a[31] ^ b[31];
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        la = lzc24(ma);
        lb = lzc24(mb);
        xa = (a[30:23] != 8'd0) ? 12'(a[30:23]) : 12'sd1 - 12'(la);
        xb = (b[30:23] != 8'd0) ? 12'(b[30:23]) : 12'sd1 - 12'(lb);
        ma = ma << la;
        mb = mb << lb;
        p = ma * mb;
        xe = xa + xb - 12'sd127;
        if (p[47]) begin
            xe = xe + 12'sd1;
        end else begin
            p = p << 1;
        end
        stk = 1'b0;
        eadj = 8'd0;
        if (xe <= 12'sd0) begin
            sh = 12'sd1 - xe;
            if (sh >= 12'sd48) begin
                stk = |p;
                p = 48'd0;
            end else begin
                stk = |(p & ((48'd1 << sh[5:0]) - 48'd1));
                p = p >> sh[5:0];
            end
        end else begin
            eadj = 8'(xe - 12'sd1);
        end
        mant = p[47:24];
        rnd = p[23] & (stk | (|p[22:0]) | mant[0]);
        mag = {eadj, 23'd0} + {7'd0, mant} + {30'd0, rnd};
        res = {sr, mag};
        if (xe >= 12'sd255) begin
            res = {sr, 8'hff, 23'd0};
        end
        if (is_nan(a)) begin
            res = a | FP_QUIET_BIT;
        end else if (is_nan(b)) begin
            res = b | FP_QUIET_BIT;
        end else if (is_inf(a) || is_inf(b)) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
                res = FP_DEFAULT_NAN;
            end else begin
                res = {sr, 8'hff, 23'd0};
            end
        end else if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
            res = {sr, 31'd0};
        end
        return res;
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b,
                                           input logic neg_b);
        logic [31:0] bn;
        logic sl;
        logic ss;
        logic [7:0] el;
        logic [7:0] es;
        logic [23:0] ml;
        logic [23:0] ms;
        logic [7:0] d;
        logic [26:0] mx;
        logic stk;
        logic [27:0] sum;
        logic [4:0] lz;
        logic signed [10:0] e;
        logic [23:0] mant;
        logic rnd;
        logic [30:0] mag;
        logic [31:0] res;
        bn = {b[31] ^ neg_b, b[30:0]};
        if (a[30:0] >= bn[30:0]) begin
            sl = a[31];
            el = a[30:23];
            ml = {(a[30:23] != 8'd0), a[22:0]};
            ss = bn[31];
            es = bn[30:23];
            ms = {(bn[30:23] != 8'd0), bn[22:0]};
        end else begin
            sl = bn[31];
            el = bn[30:23];
            ml = {(bn[30:23] != 8'd0), bn[22:0]};
            ss = a[31];
            es = a[30:23];
            ms = {(a[30:23] != 8'd0), a[22:0]};
        end
        if (el == 8'd0) begin
            el = 8'd1;
        end
        if (es == 8'd0) begin
            es = 8'd1;
        end
        d = el - es;
        mx = {ms, 3'b000};
        if (d >= 8'd27) begin
            stk = |mx;
            mx = 27'd0;
        end else begin
            stk = |(mx & ((27'd1 << d[4:0]) - 27'd1));
            mx = mx >> d[4:0];
        end
        mx[0] = mx[0] | stk;
        if (sl != ss) begin
            sum = {1'b0, ml, 3'b000} - {1'b0, mx};
        end else begin
            sum = {1'b0, ml, 3'b000} + {1'b0, mx};
        end
        e = 11'(el);
        if (sum[27]) begin
            sum = {1'b0, sum[27:2], sum[1] | sum[0]};
            e = e + 11'sd1;
        end else begin
            lz = lzc27(sum[26:0]);
            if (11'(lz) < e) begin
                sum = sum << lz;
                e = e - 11'(lz);
            end else begin
                sum = sum << 5'(e - 11'sd1);
                e = 11'sd1;
            end
        end
        mant = sum[26:3];
        rnd = sum[2] & (sum[1] | sum[0] | mant[0]);
        mag = {8'(e - 11'sd1), 23'd0} + {7'd0, mant} + {30'd0, rnd};
        res = {sl, mag};
        if (e >= 11'sd255) begin
            res = {sl, 8'hff, 23'd0};
        end
        if (sum == 28'd0) begin
            res = {sl & ss, 31'd0};
        end
        if (is_nan(a)) begin
            res = a | FP_QUIET_BIT;
        end else if (is_nan(b)) begin
            res = b | FP_QUIET_BIT;
        end else if (is_inf(a) && is_inf(bn)) begin
            res = (a[31] == bn[31]) ? a : FP_DEFAULT_NAN;
        end else if (is_inf(a)) begin
            res = a;
        end else if (is_inf(bn)) begin
            res = bn;
        end
        return res;
    endfunction

    function automatic logic [31:0] seed(input logic [31:0] m);
        return MAGIC_SEED - {m[31], m[31:1]};
    endfunction

endpackage
`default_nettype wire

/* rtl/vnfis_front.sv */
`default_nettype none
module vnfis_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [95:0]       in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output vnfis_pkg::item_t       out_item
);

    logic vld_reg;
    logic vld_next;
    vnfis_pkg::item_t item_reg;
    vnfis_pkg::item_t item_next;

    assign in_ready = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item = item_reg;

    // squares are formed here; the sum starts in the back pipeline
    always_comb begin
        vld_next = vld_reg;
        item_next = item_reg;
        if (in_ready) begin
            vld_next = in_valid;
            item_next.x = in_data[31:0];
            item_next.y = in_data[63:32];
            item_next.z = in_data[95:64];
            item_next.m = vnfis_pkg::fp_mul(in_data[31:0], in_data[31:0]);
            item_next.r = vnfis_pkg::fp_mul(in_data[63:32], in_data[63:32]);
            item_next.t = vnfis_pkg::fp_mul(in_data[95:64], in_data[95:64]);
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/vnfis_queue.sv */
`default_nettype none
module vnfis_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire vnfis_pkg::item_t  wr_item,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output vnfis_pkg::item_t       rd_item
);

    vnfis_pkg::item_t mem [vnfis_pkg::QDEPTH];
    logic [vnfis_pkg::QAW-1:0] wp_reg;
    logic [vnfis_pkg::QAW-1:0] rp_reg;
    logic [vnfis_pkg::QAW:0] cnt_reg;
    logic push;
    logic pop;

    assign wr_ready = cnt_reg < (vnfis_pkg::QAW+1)'(vnfis_pkg::QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_item = mem[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= wr_item;
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/vnfis_back.sv */
`default_nettype none
module vnfis_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire vnfis_pkg::item_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [95:0]            out_data
);

    vnfis_pkg::item_t pipe_reg [vnfis_pkg::NSTAGE];
    vnfis_pkg::item_t pipe_next [vnfis_pkg::NSTAGE];
    logic [vnfis_pkg::NSTAGE-1:0] vld_reg;
    logic adv;

    // one float operation per stage, but stage 11 multiplies x, y and z
    function automatic vnfis_pkg::item_t stage_op(input int k, input vnfis_pkg::item_t s);
        vnfis_pkg::item_t o;
        o = s;
        case (k)
            0: o.m = vnfis_pkg::fp_add(s.m, s.r, 1'b0);
            1: o.m = vnfis_pkg::fp_add(s.m, s.t, 1'b0);
            2: begin
                o.m = vnfis_pkg::fp_mul(s.m, vnfis_pkg::FP_HALF);
                o.r = vnfis_pkg::seed(s.m);
            end
            3, 7: o.t = vnfis_pkg::fp_mul(s.m, s.r);
            4, 8: o.t = vnfis_pkg::fp_mul(s.t, s.r);
            5, 9: o.t = vnfis_pkg::fp_add(vnfis_pkg::FP_THREE_HALVES, s.t, 1'b1);
            6, 10: o.r = vnfis_pkg::fp_mul(s.r, s.t);
            11: begin
                o.x = vnfis_pkg::fp_mul(s.x, s.r);
                o.y = vnfis_pkg::fp_mul(s.y, s.r);
                o.z = vnfis_pkg::fp_mul(s.z, s.r);
            end
            default: o = s;
        endcase
        return o;
    endfunction

    assign adv = !vld_reg[vnfis_pkg::NSTAGE-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[vnfis_pkg::NSTAGE-1];
    assign out_data = {pipe_reg[vnfis_pkg::NSTAGE-1].z, pipe_reg[vnfis_pkg::NSTAGE-1].y,
                       pipe_reg[vnfis_pkg::NSTAGE-1].x};

    always_comb begin
        for (int k = 0; k < vnfis_pkg::NSTAGE; k++) begin
            pipe_next[k] = stage_op(k, (k == 0) ? in_item : pipe_reg[(k == 0) ? 0 : k - 1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < vnfis_pkg::NSTAGE; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[vnfis_pkg::NSTAGE-2:0], in_valid};
        end
    end

endmodule
`default_nettype wire

/* rtl/vector_normalize_fast_inv_sqrt_unit.sv */
// An input passes the front register, the queue and then the pipeline stages to m_tvalid.
// Throughput: one vector per cycle unless the output is stalled; a 12-stage float pipeline.
// A 4-entry queue between the squaring front stage and the pipeline absorbs stalls.
// Reset: synchronous on aresetn low; clears all valid flags and the queue; no other state.
`default_nettype none
module vector_normalize_fast_inv_sqrt_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // comp_x, comp_y, comp_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata    // norm_x, norm_y, norm_z
);

    logic f_valid;
    logic f_ready;
    vnfis_pkg::item_t f_item;
    logic q_valid;
    logic q_ready;
    vnfis_pkg::item_t q_item;

    vnfis_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    vnfis_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    vnfis_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

endmodule
`default_nettype wire

/* rtl/vnfis_checker.sv */
`default_nettype none
module vnfis_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);

    logic [5:0] pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 6'(s_tvalid && s_tready) - 6'(m_tvalid && m_tready);
        end
    end

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("m_tvalid dropped");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("m_tdata changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("m_tvalid after reset");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 6'd0) else $error("result without input");

endmodule

bind vector_normalize_fast_inv_sqrt_unit vnfis_checker u_vnfis_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
